// ===== hdl/binary_max_heap_queue_core_assert.svh =====
// Assertion macros for the binary max-heap queue core.
`ifndef BINARY_MAX_HEAP_QUEUE_CORE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bmhq_pkg.sv =====
// Shared types and constants of the binary max-heap queue.
package bmhq_pkg;

	localparam int DEPTH         = 64;
	localparam int PRIORITY_BITS = 16;
	localparam int PAYLOAD_BITS  = 32;
	localparam int COUNT_BITS    = 7;

	typedef enum logic {
		FN_PUT = 1'b0,
		FN_POP = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		func_t                           func;
		logic signed [PRIORITY_BITS-1:0] priority_req;
		logic [PAYLOAD_BITS-1:0]         payload;
	} req_t;

	typedef struct packed {
		status_t                         status;
		logic [PAYLOAD_BITS-1:0]         out_payload;
		logic signed [PRIORITY_BITS-1:0] out_priority;
		logic [COUNT_BITS-1:0]           count;
	} rsp_t;

	typedef struct packed {
		logic signed [PRIORITY_BITS-1:0] prio;
		logic [PAYLOAD_BITS-1:0]         data;
	} entry_t;

endpackage

// ===== hdl/binary_max_heap_queue_core.sv =====
// Binary max-heap queue: one request at a time, sifted with one comparator over heap memory.
// A refused put or an empty pop answers in the cycle after the request; busy stays low.
// A put sifts up, S_UP_RD then S_UP_CMP per level, ending at the root or where it rests.
// A pop moves the last entry to the root and sifts it down, S_DN_L to S_DN_C2 per level.
// The one-cycle result strobe cannot be stalled; the next request is taken as it shows.
// Reset clears the entry count and the sequencer; heap memory is not cleared.
`include "binary_max_heap_queue_core_assert.svh"

module binary_max_heap_queue_core #(
	parameter int DEPTH = bmhq_pkg::DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bmhq_pkg::req_t req,
	output logic           done,
	output bmhq_pkg::rsp_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_raddr;
	bmhq_pkg::entry_t mem_wdata;
	bmhq_pkg::entry_t mem_rdata;
	logic             rsp_refused;
	logic             rsp_full;
	logic             rsp_no_entry;
	logic             rsp_count_full;

	bmhq_seq #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	bmhq_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rsp_refused    = done && (rsp.status != bmhq_pkg::ST_DONE);
	assign rsp_full       = done && (rsp.status == bmhq_pkg::ST_FULL);
	assign rsp_no_entry   = (rsp.out_payload == '0) && (rsp.out_priority == '0);
	assign rsp_count_full = (rsp.count == bmhq_pkg::COUNT_BITS'(DEPTH));

	`BMHQ_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobe while sequencer busy")
	`BMHQ_ASSERT_NEXT(a_request_taken, start && !busy, busy || done, "accepted request dropped")
	`BMHQ_ASSERT_NOW(a_reject_zero, rsp_refused, rsp_no_entry, "refused request returned an entry")
	`BMHQ_ASSERT_NOW(a_full_count, rsp_full, rsp_count_full, "full status without a full heap")

endmodule

// ===== hdl/bmhq_mem.sv =====
// Heap entry storage: one write port and one registered read port.
module bmhq_mem #(
	parameter int DEPTH = bmhq_pkg::DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  bmhq_pkg::entry_t wdata,
	input  logic [AW-1:0]    raddr,
	output bmhq_pkg::entry_t rdata
);

	bmhq_pkg::entry_t mem_q [DEPTH];
	bmhq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/bmhq_seq.sv =====
// Sequencer that sifts heap entries with one shared priority comparator.
module bmhq_seq #(
	parameter int DEPTH = bmhq_pkg::DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bmhq_pkg::req_t   req,
	output logic             done,
	output bmhq_pkg::rsp_t   rsp,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output bmhq_pkg::entry_t mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	input  bmhq_pkg::entry_t mem_rdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = AW + 2;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_RD_LAST  = 9'b000000010,
		S_LD_LAST  = 9'b000000100,
		S_UP_RD    = 9'b000001000,
		S_UP_CMP   = 9'b000010000,
		S_DN_L     = 9'b000100000,
		S_DN_R     = 9'b001000000,
		S_DN_C1    = 9'b010000000,
		S_DN_C2    = 9'b100000000
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    pick_pos_q;
	logic [CW-1:0]    cnt_q;
	bmhq_pkg::entry_t node_q;
	bmhq_pkg::entry_t left_q;
	bmhq_pkg::entry_t pick_q;
	bmhq_pkg::entry_t root_q;
	bmhq_pkg::rsp_t   rsp_q;
	logic             done_q;

	logic                                      accept;
	logic [AW-1:0]                             parent;
	logic [XW-1:0]                             left_w;
	logic [XW-1:0]                             right_w;
	logic [XW-1:0]                             cnt_w;
	logic                                      left_ok;
	logic                                      right_ok;
	logic signed [bmhq_pkg::PRIORITY_BITS-1:0] cmp_a;
	logic signed [bmhq_pkg::PRIORITY_BITS-1:0] cmp_b;
	logic                                      cmp_gt;

	assign accept   = start && (state_q == S_IDLE);
	assign parent   = (pos_q - AW'(1)) >> 1;
	assign left_w   = {1'b0, pos_q, 1'b1};
	assign right_w  = left_w + XW'(1);
	assign cnt_w    = XW'(cnt_q);
	assign left_ok  = left_w < cnt_w;
	assign right_ok = right_w < cnt_w;

	// The single comparator; its operands follow the sequencer step.
	always_comb begin
		case (state_q)
			S_DN_C1: begin
				cmp_a = mem_rdata.prio;
				cmp_b = left_q.prio;
			end
			S_DN_C2: begin
				cmp_a = pick_q.prio;
				cmp_b = node_q.prio;
			end
			default: begin
				cmp_a = node_q.prio;
				cmp_b = mem_rdata.prio;
			end
		endcase
	end

	assign cmp_gt = cmp_a > cmp_b;

	// Memory port control. The moving entry stays in node_q and is written
	// only where it comes to rest; displaced entries move into the hole.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = node_q;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				mem_raddr = '0;
			end
			S_RD_LAST: begin
				mem_raddr = AW'(cnt_q - CW'(1));
			end
			S_UP_RD: begin
				mem_raddr = parent;
				mem_we    = (pos_q == '0);
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (cmp_gt) begin
					mem_wdata = mem_rdata;
				end
			end
			S_DN_L: begin
				mem_raddr = left_w[AW-1:0];
				mem_we    = !left_ok;
			end
			S_DN_R: begin
				mem_raddr = right_w[AW-1:0];
			end
			S_DN_C2: begin
				mem_we = 1'b1;
				if (cmp_gt) begin
					mem_wdata = pick_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.func == bmhq_pkg::FN_PUT) begin
							if (cnt_q == CW'(DEPTH)) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_RD_LAST;
							end
						end
					end
				end
				S_RD_LAST: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_LD_LAST;
				end
				S_LD_LAST: begin
					state_q <= S_DN_L;
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						cnt_q   <= cnt_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cmp_gt) begin
						state_q <= S_UP_RD;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN_L: begin
					if (left_ok) begin
						state_q <= S_DN_R;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN_R: begin
					state_q <= S_DN_C1;
				end
				S_DN_C1: begin
					state_q <= S_DN_C2;
				end
				S_DN_C2: begin
					if (cmp_gt) begin
						state_q <= S_DN_L;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers and the result word.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				node_q.prio        <= req.priority_req;
				node_q.data        <= req.payload;
				pos_q              <= AW'(cnt_q);
				rsp_q.out_payload  <= '0;
				rsp_q.out_priority <= '0;
				rsp_q.count        <= bmhq_pkg::COUNT_BITS'(cnt_q);
				if (req.func == bmhq_pkg::FN_PUT) begin
					rsp_q.status <= bmhq_pkg::ST_FULL;
				end else begin
					rsp_q.status <= bmhq_pkg::ST_EMPTY;
				end
			end
			S_RD_LAST: begin
				root_q <= mem_rdata;
			end
			S_LD_LAST: begin
				node_q <= mem_rdata;
				pos_q  <= '0;
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					rsp_q.status <= bmhq_pkg::ST_DONE;
					rsp_q.count  <= bmhq_pkg::COUNT_BITS'(cnt_q + CW'(1));
				end
			end
			S_UP_CMP: begin
				if (cmp_gt) begin
					pos_q <= parent;
				end else begin
					rsp_q.status <= bmhq_pkg::ST_DONE;
					rsp_q.count  <= bmhq_pkg::COUNT_BITS'(cnt_q + CW'(1));
				end
			end
			S_DN_L: begin
				if (!left_ok) begin
					rsp_q.status       <= bmhq_pkg::ST_DONE;
					rsp_q.out_payload  <= root_q.data;
					rsp_q.out_priority <= root_q.prio;
					rsp_q.count        <= bmhq_pkg::COUNT_BITS'(cnt_q);
				end
			end
			S_DN_R: begin
				left_q <= mem_rdata;
			end
			S_DN_C1: begin
				// The right child wins only when it is present and strictly greater.
				if (right_ok && cmp_gt) begin
					pick_q     <= mem_rdata;
					pick_pos_q <= right_w[AW-1:0];
				end else begin
					pick_q     <= left_q;
					pick_pos_q <= left_w[AW-1:0];
				end
			end
			S_DN_C2: begin
				if (cmp_gt) begin
					pos_q <= pick_pos_q;
				end else begin
					rsp_q.status       <= bmhq_pkg::ST_DONE;
					rsp_q.out_payload  <= root_q.data;
					rsp_q.out_priority <= root_q.prio;
					rsp_q.count        <= bmhq_pkg::COUNT_BITS'(cnt_q);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== test/binary_max_heap_queue_core_tb.sv =====
// Self-checking testbench of the binary max-heap queue core with its own heap predictor.
module binary_max_heap_queue_core_tb;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 950;
	localparam int MAX_GAP      = 20;

	// Keeps its own copy of the heap and the queue of answers still owed by the core.
	class heap_scoreboard;
		bmhq_pkg::entry_t slots[bmhq_pkg::DEPTH];
		int               held;
		bmhq_pkg::rsp_t   owed_answers[$];
		int               errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		function int pending();
			return owed_answers.size();
		endfunction

		function bmhq_pkg::rsp_t apply_request(bmhq_pkg::req_t r);
			bmhq_pkg::rsp_t   ans;
			bmhq_pkg::entry_t tmp;
			int               pos;
			int               up;
			int               lft;
			int               pick;
			ans        = '0;
			ans.status = bmhq_pkg::ST_DONE;
			if (r.func == bmhq_pkg::FN_PUT) begin
				if (held >= bmhq_pkg::DEPTH) begin
					ans.status = bmhq_pkg::ST_FULL;
				end else begin
					slots[held].prio = r.priority_req;
					slots[held].data = r.payload;
					pos = held;
					// A new entry climbs only past parents it strictly beats.
					while (pos > 0) begin
						up = (pos - 1) / 2;
						if (!(slots[pos].prio > slots[up].prio))
							break;
						tmp         = slots[pos];
						slots[pos]  = slots[up];
						slots[up]   = tmp;
						pos         = up;
					end
					held++;
				end
			end else begin
				if (held == 0) begin
					ans.status = bmhq_pkg::ST_EMPTY;
				end else begin
					ans.out_payload  = slots[0].data;
					ans.out_priority = slots[0].prio;
					held--;
					slots[0] = slots[held];
					pos = 0;
					// The right child wins only when strictly greater than the left one.
					while (2 * pos + 1 < held) begin
						lft  = 2 * pos + 1;
						pick = lft;
						if (lft + 1 < held && slots[lft + 1].prio > slots[lft].prio)
							pick = lft + 1;
						if (!(slots[pick].prio > slots[pos].prio))
							break;
						tmp          = slots[pos];
						slots[pos]   = slots[pick];
						slots[pick]  = tmp;
						pos          = pick;
					end
				end
			end
			ans.count = bmhq_pkg::COUNT_BITS'(held);
			return ans;
		endfunction

		function void note_request(bmhq_pkg::req_t r);
			owed_answers.push_back(apply_request(r));
		endfunction

		function void flag_field(string field, logic [63:0] want, logic [63:0] got);
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
			errors++;
		endfunction

		function void check_response(bmhq_pkg::rsp_t got);
			bmhq_pkg::rsp_t want;
			if (owed_answers.size() == 0) begin
				$display("%0t: response with no request outstanding, expected none actual %0h",
					$time, got);
				errors++;
				return;
			end
			want = owed_answers.pop_front();
			if (got.status !== want.status)
				flag_field("status", 64'(want.status), 64'(got.status));
			if (got.out_payload !== want.out_payload)
				flag_field("out_payload", 64'(want.out_payload), 64'(got.out_payload));
			if (got.out_priority !== want.out_priority)
				flag_field("out_priority", 64'(want.out_priority), 64'(got.out_priority));
			if (got.count !== want.count)
				flag_field("count", 64'(want.count), 64'(got.count));
		endfunction
	endclass

	logic           clk    = 1'b0;
	logic           arst_n = 1'b0;
	logic           start  = 1'b0;
	bmhq_pkg::req_t req    = '0;
	logic           busy;
	logic           done;
	bmhq_pkg::rsp_t rsp;

	heap_scoreboard sb = new();
	int             idle_pct = 0;
	int             quiet_cycles = 0;

	binary_max_heap_queue_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// A response seen at this edge always belongs to an earlier request, so check first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_response(rsp);
			if (start && !busy)
				sb.note_request(req);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("binary_max_heap_queue_core_tb: done, errors");
				$finish;
			end
		end
	end

	function automatic bmhq_pkg::req_t make_put(
		logic signed [bmhq_pkg::PRIORITY_BITS-1:0] p,
		logic [bmhq_pkg::PAYLOAD_BITS-1:0] d);
		bmhq_pkg::req_t r;
		r.func         = bmhq_pkg::FN_PUT;
		r.priority_req = p;
		r.payload      = d;
		return r;
	endfunction

	function automatic bmhq_pkg::req_t make_pop();
		bmhq_pkg::req_t r;
		r.func         = bmhq_pkg::FN_POP;
		r.priority_req = bmhq_pkg::PRIORITY_BITS'($urandom);
		r.payload      = bmhq_pkg::PAYLOAD_BITS'($urandom);
		return r;
	endfunction

	function automatic bmhq_pkg::req_t random_request(int put_pct);
		logic signed [bmhq_pkg::PRIORITY_BITS-1:0] p;
		if ($urandom_range(99) >= put_pct)
			return make_pop();
		// Narrow ranges make ties common; extremes and full-range values cover every bit.
		case ($urandom_range(3))
			0: p = bmhq_pkg::PRIORITY_BITS'($urandom_range(8) - 4);
			1: begin
				case ($urandom_range(3))
					0: p = 16'sh8000;
					1: p = 16'sh7fff;
					2: p = '0;
					default: p = '1;
				endcase
			end
			default: p = bmhq_pkg::PRIORITY_BITS'($urandom);
		endcase
		return make_put(p, bmhq_pkg::PAYLOAD_BITS'($urandom));
	endfunction

	task automatic send_request(input bmhq_pkg::req_t r);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		int idle_levels[3];
		int sent;
		int seg;
		int seg_len;
		int put_pct;
		idle_levels = '{0, 69, 37};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, extreme priorities and payloads, ties, then drain past empty.
		send_request(make_pop());
		send_request(make_put(16'sh7fff, 32'hffff_ffff));
		send_request(make_put(16'sh8000, 32'h0000_0000));
		send_request(make_put(16'sh0000, 32'h0000_0001));
		send_request(make_put(-16'sd1, 32'h8000_0000));
		send_request(make_put(16'sd5, 32'h0000_00a1));
		send_request(make_put(16'sd5, 32'h0000_00a2));
		send_request(make_put(16'sd5, 32'h0000_00a3));
		send_request(make_put(16'sh7fff, 32'h5555_aaaa));
		send_request(make_put(16'sd5, 32'h0000_00a4));
		repeat (10) send_request(make_pop());

		// Random: bursts that lean toward filling, balancing or draining the queue.
		sent = 0;
		seg  = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_pct = idle_levels[seg % 3];
			if (seg == 0) begin
				// The first burst overfills the queue so full refusals are certain.
				put_pct = 100;
				seg_len = 70;
			end else begin
				case ($urandom_range(2))
					0: put_pct = 90;
					1: put_pct = 50;
					default: put_pct = 12;
				endcase
				seg_len = $urandom_range(80, 20);
			end
			repeat (seg_len) begin
				send_request(random_request(put_pct));
				sent++;
			end
			seg++;
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("binary_max_heap_queue_core_tb: done, clean");
		end else begin
			$display("binary_max_heap_queue_core_tb: done, errors");
		end
		$finish;
	end

endmodule
